FILE: hw/rtl/eafd_pkg.sv
// shared types and constants for the escaped api frame deframer
`timescale 1ns / 1ps

package eafd_pkg;

  localparam logic [7:0] DELIM_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] GOOD_SUM   = 8'hFF;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // one classified frame byte handed from front to back
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } tok_t;

  // push request from front end into the token queue
  typedef struct packed {
    logic valid;
    tok_t tok;
  } push_t;

  // token queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: hw/rtl/eafd_front.sv
// front end: delimiter hunt, unescaping, length field and byte classification
`timescale 1ns / 1ps

module eafd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    rx_byte,
  output eafd_pkg::push_t push
);
  import eafd_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_LEN_HI  = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_CONTENT = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  ub;
  logic        take;

  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    len_hi_nxt = len_hi_r;
    rem_nxt    = rem_r;
    push       = '0;
    ub         = esc_r ? (rx_byte ^ ESC_XOR) : rx_byte;
    take       = 1'b0;
    if (acc) begin
      if (phase_r == PH_IDLE) begin
        if (rx_byte == DELIM_BYTE) begin
          phase_nxt = PH_LEN_HI;
          esc_nxt   = 1'b0;
        end
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        take    = 1'b1;
      end else if (rx_byte == ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        take = 1'b1;
      end
      if (take) begin
        unique case (phase_r)
          PH_LEN_HI: begin
            len_hi_nxt = ub;
            phase_nxt  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            rem_nxt   = {len_hi_r, ub};
            phase_nxt = ({len_hi_r, ub} == 16'd0) ? PH_CHECK : PH_CONTENT;
          end
          PH_CONTENT: begin
            push.valid    = 1'b1;
            push.tok.data = ub;
            push.tok.last = 1'b0;
            rem_nxt       = rem_r - 16'd1;
            if (rem_r == 16'd1) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            push.valid    = 1'b1;
            push.tok.data = ub;
            push.tok.last = 1'b1;
            phase_nxt     = PH_IDLE;
            esc_nxt       = 1'b0;
            rem_nxt       = 16'd0;
          end
          default: begin
            phase_nxt = PH_IDLE;
            esc_nxt   = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      esc_r    <= 1'b0;
      len_hi_r <= 8'd0;
      rem_r    <= 16'd0;
    end else begin
      phase_r  <= phase_nxt;
      esc_r    <= esc_nxt;
      len_hi_r <= len_hi_nxt;
      rem_r    <= rem_nxt;
    end
  end

  a_esc_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (phase_r != PH_IDLE))
    else $error("escape pending while hunting for delimiter");

  a_content_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CONTENT) |-> (rem_r != 16'd0))
    else $error("content phase with no bytes remaining");

  a_push_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> acc)
    else $error("token pushed without an accepted byte");

endmodule

FILE: hw/rtl/eafd_fifo.sv
// short token queue between front end and back end
`timescale 1ns / 1ps

module eafd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  eafd_pkg::push_t push,
  input  logic            pop,
  output eafd_pkg::tok_t  head,
  output eafd_pkg::qstat_t stat
);
  import eafd_pkg::*;

  tok_t            mem [QDEPTH];
  logic [QAW-1:0]  wp_r, wp_nxt;
  logic [QAW-1:0]  rp_r, rp_nxt;
  logic [QAW:0]    cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem[rp_r];
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = do_pop  ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !stat.full)
    else $error("token pushed into full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == cnt_r[QAW-1:0])
    else $error("queue pointers disagree with count");

endmodule

FILE: hw/rtl/eafd_back.sv
// back end: running checksum and registered result stage
`timescale 1ns / 1ps

module eafd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  eafd_pkg::tok_t   head,
  input  eafd_pkg::qstat_t stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_data_byte,
  output logic             out_last,
  output logic             out_checksum_ok
);
  import eafd_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       ok_r;
  logic [7:0] total;

  assign pop   = !stat.empty && (!vld_r || out_ready);
  assign total = sum_r + head.data;

  always_comb begin
    vld_nxt = vld_r;
    sum_nxt = sum_r;
    if (out_ready) begin
      vld_nxt = 1'b0;
    end
    if (pop) begin
      vld_nxt = 1'b1;
      sum_nxt = head.last ? 8'd0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sum_r <= 8'd0;
    end else begin
      vld_r <= vld_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head.data;
      last_r <= head.last;
      ok_r   <= head.last && (total == GOOD_SUM);
    end
  end

  assign out_valid       = vld_r;
  assign out_data_byte   = data_r;
  assign out_last        = last_r;
  assign out_checksum_ok = ok_r;

  a_ok_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !last_r) |-> !ok_r)
    else $error("checksum flag on a content result");

  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.last) |=> (sum_r == 8'd0))
    else $error("running sum not cleared after checksum");

  a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!vld_r || out_ready))
    else $error("result overwritten before it was taken");

endmodule

FILE: hw/rtl/escaped_api_frame_deframer.sv
// top level of the escaped api frame deframer
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_rx_byte           | sink
//   out     | out_valid, out_ready, out_data_byte,     | source
//           | out_last, out_checksum_ok                |
//
// one byte per cycle while in_ready is high; a content or checksum byte reaches the
// output after its transaction through the queue write, then the result reg
// reset (rst_n low, synchronous) returns to delimiter hunt with queue empty
// in_ready is low only when the four-entry token queue is full, which
// happens only after out_ready has been held low for several results
// escape, delimiter and length bytes never occupy a queue entry
`timescale 1ns / 1ps

module escaped_api_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_last,
  output logic       out_checksum_ok
);
  import eafd_pkg::*;

  push_t  push;
  tok_t   head;
  qstat_t stat;
  logic   pop;
  logic   acc;

  // input transaction only when the queue can take a token
  assign in_ready = !stat.full;
  assign acc      = in_valid && in_ready;

  // delimiter hunt, unescape, length count
  eafd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_byte (in_rx_byte),
    .push    (push)
  );

  // decouples byte intake from result stalls
  eafd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  // checksum accumulate and output register
  eafd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .stat            (stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last),
    .out_checksum_ok (out_checksum_ok)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> in_ready)
    else $error("input stalled with empty queue");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!stat.empty && !out_valid) |-> pop)
    else $error("back end idle while tokens wait");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("popped token produced no result");

endmodule
